// File: rtl/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the delimited token splitter.
// ----------------------------------------------------------------------------
package dts_pkg;

   // Special bytes
   localparam logic [7:0] QUOTE_BYTE     = 8'h22;
   localparam logic [7:0] BACKSLASH_BYTE = 8'h5C;
   localparam logic [7:0] SPACE_BYTE     = 8'h20;
   localparam logic [7:0] TAB_BYTE       = 8'h09;
   localparam logic [7:0] CR_BYTE        = 8'h0D;

   // Delimiter slots packed in the delimiter register
   localparam int MAX_DELIMITERS = 4;

   // Configuration register indexes
   localparam int          CSR_ADDR_W      = 2;
   localparam logic [1:0]  REG_OPTIONS     = 2'd0;
   localparam logic [1:0]  REG_DELIM_CHARS = 2'd1;
   localparam logic [1:0]  REG_DELIM_COUNT = 2'd2;

   // Option bits
   localparam int OPT_QUOTES      = 0;
   localparam int OPT_EMPTY       = 1;
   localparam int OPT_STRIP_LEAD  = 2;
   localparam int OPT_STRIP_TRAIL = 3;
   localparam int OPT_KEEP_QUOTES = 4;
   localparam int OPT_KEEP_ESC    = 5;

   localparam logic [5:0]  OPTIONS_RESET     = 6'd1;
   localparam logic [31:0] DELIM_CHARS_RESET = 32'd32;
   localparam logic [2:0]  DELIM_COUNT_RESET = 3'd1;

   // Controller phases, in execution order
   localparam int         PHASE_W  = 3;
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BS    = 3'd1;
   localparam logic [2:0] ST_BYTE  = 3'd2;
   localparam logic [2:0] ST_END   = 3'd3;
   localparam logic [2:0] ST_XEND  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // Work needed by one input byte
   typedef struct packed {
      logic emit_bs;    // send a backslash first
      logic main_emit;  // send or hold the byte itself
      logic do_end;     // close the token
      logic extra_end;  // extra empty token after a final delimiter
   } dts_plan_type;

   typedef struct packed {
      logic                accept;
      logic                go;
      logic [PHASE_W-1:0]  phase;
   } dts_cmd_type;

   typedef struct packed {
      dts_plan_type plan_d;  // decode of the byte on the input
      dts_plan_type plan_q;  // decode of the byte in progress
      logic         room;    // a result can be staged this cycle
      logic         done;    // current phase finishes this cycle
   } dts_sts_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       valid;
      logic       tend;
      logic       ovf;
   } dts_res_type;

endpackage

// File: rtl/dts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_datapath
// Config registers, byte decode, token state, held-whitespace shift store
// and the staging/output registers of the result stream.
// ----------------------------------------------------------------------------
module dts_datapath
   import dts_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dts_cmd_type           cmd,
   output dts_sts_type           sts,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [2:0]            rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [31:0]           csr_wdata
);

   localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);

   function automatic logic is_ws(input logic [7:0] c);
      return (c == SPACE_BYTE) || (c >= TAB_BYTE && c <= CR_BYTE);
   endfunction

   function automatic logic is_delim(input logic [7:0] c, input logic [31:0] chars,
                                     input logic [2:0] cnt);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < MAX_DELIMITERS; i++) begin
         if (3'(i) < cnt && chars[8*i +: 8] != 8'd0 && chars[8*i +: 8] == c) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   // Configuration
   logic [5:0]  opt_ff;
   logic [31:0] dchars_ff;
   logic [2:0]  dcount_ff;

   // Byte in progress
   logic [7:0]   char_ff;
   dts_plan_type plan_ff;

   // Token state
   logic inq_ff, start_ff, tok_ff, pend_ff;

   // Held whitespace
   logic [7:0]    held_ff [HELD_SPACE_DEPTH];
   logic [7:0]    held_in [HELD_SPACE_DEPTH];
   logic [7:0]    shifted [HELD_SPACE_DEPTH];
   logic [CW-1:0] cnt_ff, cnt_in, widx;

   // Result staging and output
   dts_res_type stg_ff, out_ff, cand;
   logic        stg_valid_ff, out_valid_ff, out_last_ff;

   // Decode
   dts_plan_type plan_d;
   logic inq_n, start_n, pend_n, esc, delim_c;

   // Phase action
   logic cand_en, pop, push, clr, tok_set, end_reset, done;
   logic hold, full, empty, drop;

   always_comb begin
      esc     = pend_ff && (req_tdata == QUOTE_BYTE || req_tdata == BACKSLASH_BYTE);
      delim_c = is_delim(req_tdata, dchars_ff, dcount_ff);
      plan_d  = '0;
      inq_n   = inq_ff;
      start_n = start_ff;
      pend_n  = 1'b0;
      if (pend_ff) begin
         plan_d.emit_bs = esc ? opt_ff[OPT_KEEP_ESC] : 1'b1;
      end
      if (esc) begin
         plan_d.main_emit = 1'b1;
         start_n          = 1'b0;
      end else if (!inq_ff && delim_c) begin
         plan_d.do_end = 1'b1;
      end else if (opt_ff[OPT_QUOTES] && req_tdata == QUOTE_BYTE) begin
         plan_d.main_emit = opt_ff[OPT_KEEP_QUOTES];
         inq_n            = !inq_ff;
      end else if (inq_ff && req_tdata == BACKSLASH_BYTE && !req_tlast) begin
         pend_n  = 1'b1;
         start_n = 1'b0;
      end else if (!inq_ff && opt_ff[OPT_STRIP_LEAD] && start_ff && is_ws(req_tdata)) begin
         plan_d.main_emit = 1'b0;
      end else begin
         start_n          = 1'b0;
         plan_d.main_emit = 1'b1;
      end
      if (req_tlast) begin
         plan_d.do_end = 1'b1;
      end
      plan_d.extra_end = req_tlast && opt_ff[OPT_EMPTY] && delim_c;
   end

   // At most one result and one store update per cycle of a phase, applied only while cmd.go is set
   always_comb begin
      hold      = opt_ff[OPT_STRIP_TRAIL] && is_ws(char_ff);
      full      = (cnt_ff == CW'(HELD_SPACE_DEPTH));
      empty     = (cnt_ff == '0);
      drop      = opt_ff[OPT_STRIP_TRAIL] && !inq_ff;
      cand      = '0;
      cand_en   = 1'b0;
      pop       = 1'b0;
      push      = 1'b0;
      clr       = 1'b0;
      tok_set   = 1'b0;
      end_reset = 1'b0;
      done      = 1'b0;
      unique case (cmd.phase)
         ST_BS: begin
            cand_en = 1'b1;
            tok_set = 1'b1;
            done    = empty;
            if (!empty) begin
               cand = '{ch: held_ff[0], valid: 1'b1, tend: 1'b0, ovf: 1'b0};
               pop  = 1'b1;
            end else begin
               cand = '{ch: BACKSLASH_BYTE, valid: 1'b1, tend: 1'b0, ovf: 1'b0};
            end
         end
         ST_BYTE: begin
            if (hold) begin
               done = 1'b1;
               push = 1'b1;
               if (full) begin
                  cand    = '{ch: held_ff[0], valid: 1'b1, tend: 1'b0, ovf: 1'b1};
                  cand_en = 1'b1;
                  pop     = 1'b1;
                  tok_set = 1'b1;
               end
            end else begin
               cand_en = 1'b1;
               tok_set = 1'b1;
               done    = empty;
               if (!empty) begin
                  cand = '{ch: held_ff[0], valid: 1'b1, tend: 1'b0, ovf: 1'b0};
                  pop  = 1'b1;
               end else begin
                  cand = '{ch: char_ff, valid: 1'b1, tend: 1'b0, ovf: 1'b0};
               end
            end
         end
         ST_END: begin
            if (!drop && !empty) begin
               cand    = '{ch: held_ff[0], valid: 1'b1, tend: 1'b0, ovf: 1'b0};
               cand_en = 1'b1;
               pop     = 1'b1;
               tok_set = 1'b1;
            end else begin
               cand      = '{ch: 8'd0, valid: 1'b0, tend: 1'b1, ovf: 1'b0};
               cand_en   = tok_ff || opt_ff[OPT_EMPTY];
               clr       = 1'b1;
               end_reset = 1'b1;
               done      = 1'b1;
            end
         end
         ST_XEND: begin
            cand    = '{ch: 8'd0, valid: 1'b0, tend: 1'b1, ovf: 1'b0};
            cand_en = 1'b1;
            done    = 1'b1;
         end
         ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   // Shift store: entry 0 is the oldest byte
   always_comb begin
      for (int i = 0; i < HELD_SPACE_DEPTH - 1; i++) begin
         shifted[i] = held_ff[i+1];
      end
      shifted[HELD_SPACE_DEPTH-1] = held_ff[HELD_SPACE_DEPTH-1];
      widx = (cmd.go && pop) ? cnt_ff - CW'(1) : cnt_ff;
      for (int i = 0; i < HELD_SPACE_DEPTH; i++) begin
         held_in[i] = (cmd.go && pop) ? shifted[i] : held_ff[i];
         if (cmd.go && push && widx == CW'(i)) begin
            held_in[i] = char_ff;
         end
      end
      cnt_in = cnt_ff;
      if (cmd.go) begin
         if (clr) begin
            cnt_in = '0;
         end else begin
            cnt_in = cnt_ff + CW'(push) - CW'(pop);
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opt_ff    <= OPTIONS_RESET;
         dchars_ff <= DELIM_CHARS_RESET;
         dcount_ff <= DELIM_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_OPTIONS:     opt_ff    <= csr_wdata[5:0];
            REG_DELIM_CHARS: dchars_ff <= csr_wdata;
            REG_DELIM_COUNT: dcount_ff <= csr_wdata[2:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff <= req_tdata;
         plan_ff <= plan_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff   <= 1'b0;
         start_ff <= 1'b1;
         tok_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.accept) begin
            inq_ff   <= inq_n;
            start_ff <= start_n;
            pend_ff  <= pend_n;
         end
         if (cmd.go && tok_set) begin
            tok_ff <= 1'b1;
         end
         if (cmd.go && end_reset) begin
            inq_ff   <= 1'b0;
            start_ff <= 1'b1;
            tok_ff   <= 1'b0;
            pend_ff  <= 1'b0;
         end
      end
   end

   // Results pass through a one-deep stage so the final one can be tagged
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.go && cand_en) begin
            if (stg_valid_ff) begin
               out_ff      <= stg_ff;
               out_last_ff <= 1'b0;
            end
            stg_ff       <= cand;
            stg_valid_ff <= 1'b1;
         end
         if (cmd.go && cmd.phase == ST_DONE && stg_valid_ff) begin
            out_ff       <= stg_ff;
            out_last_ff  <= 1'b1;
            stg_valid_ff <= 1'b0;
         end
         if (cmd.go && stg_valid_ff && (cand_en || cmd.phase == ST_DONE)) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.plan_d = plan_d;
   assign sts.plan_q = plan_ff;
   assign sts.room   = !stg_valid_ff || !out_valid_ff || rsp_tready;
   assign sts.done   = done;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.ch;
   assign rsp_tuser  = {out_ff.ovf, out_ff.tend, out_ff.valid};
   assign rsp_tlast  = out_last_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(HELD_SPACE_DEPTH))
      else $error("held count beyond store depth");

   a_end_mark_empty: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.tend |-> !out_ff.valid && out_ff.ch == 8'd0)
      else $error("token end carries a byte");

   a_stage_empty_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.phase == ST_IDLE |-> !stg_valid_ff)
      else $error("staged result left behind between bytes");

endmodule

// File: rtl/dts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ctrl
// Phase sequencer: walks the work of one byte, at most one result per cycle while the output has room.
// ----------------------------------------------------------------------------
module dts_ctrl
   import dts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dts_sts_type sts,
   output dts_cmd_type cmd
);

   logic [PHASE_W-1:0] state_ff, state_in;
   logic               accept, go;

   // first enabled phase after cur
   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] cur,
                                                     input dts_plan_type p);
      logic [PHASE_W-1:0] nxt;
      nxt = ST_DONE;
      if (cur < ST_XEND && p.extra_end) nxt = ST_XEND;
      if (cur < ST_END && p.do_end) nxt = ST_END;
      if (cur < ST_BYTE && p.main_emit) nxt = ST_BYTE;
      if (cur < ST_BS && p.emit_bs) nxt = ST_BS;
      return nxt;
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign go         = (state_ff != ST_IDLE) && sts.room;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff) inside
         ST_IDLE: begin
            if (accept) state_in = next_phase(ST_IDLE, sts.plan_d);
         end
         ST_BS, ST_BYTE, ST_END, ST_XEND: begin
            if (go && sts.done) state_in = next_phase(state_ff, sts.plan_q);
         end
         ST_DONE: begin
            if (go) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.accept = accept;
   assign cmd.go     = go;
   assign cmd.phase  = state_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted byte not started");

   a_done_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && sts.room |=> state_ff == ST_IDLE)
      else $error("closing phase did not return to idle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE && !sts.room |=> state_ff == $past(state_ff))
      else $error("phase moved while output stalled");

endmodule

// File: rtl/delimited_token_splitter_unit.sv
`timescale 1ns / 1ps
// A byte transfers only in idle; each of its results goes through the stage and
//   output registers, the tlast result in the cycle after the closing phase.
// The next byte is taken once the controller is back in idle; a byte gives up to
//   depth + 4 results, and a held push or an unreported token end gives none.
// Reset: synchronous, active high; config returns to defaults, token state and
//   held count clear, held store contents are left as they are.
// ----------------------------------------------------------------------------
// delimited_token_splitter_unit
// Splits a byte stream into tokens on a configurable delimiter set, with
// quote grouping, escapes, whitespace stripping and empty-token reporting.
// ----------------------------------------------------------------------------
module delimited_token_splitter_unit
   import dts_pkg::*;
#(
   parameter int HELD_SPACE_DEPTH = 8   // trailing-whitespace store, 1..64
) (
   input  logic                  clock,
   input  logic                  reset,
   // input bytes
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_in
   input  logic                  req_tlast,   // last_char
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_char
   output logic [2:0]            rsp_tuser,   // [0] char_valid [1] token_end
                                              // [2] strip_overflow
   output logic                  rsp_tlast,   // last_of_run
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,    // 0 options, 1 delim chars, 2 delim count
   input  logic [31:0]           csr_wdata
);

   // Controller and datapath talk only through these two bundles.
   dts_cmd_type cmd;
   dts_sts_type sts;

   // Controller: idle -> [backslash] -> [byte] -> [token end] -> [extra end]
   // -> done. Phases that flush held whitespace loop one byte per cycle.
   // Any phase cycle stalls while the stage and output register are both full and rsp_tready is low.
   dts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath: decodes the byte at transfer, keeps the token state and the
   // whitespace shift store, and stages each result one deep so the last
   // result of a byte can carry tlast once the closing phase is reached.
   dts_datapath #(
      .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule
